// ===== sv/gyro_flick_detector_assert.svh =====
// Assertion macros shared by the gyro flick detector RTL.
`ifndef GYRO_FLICK_DETECTOR_ASSERT_SVH
`define GYRO_FLICK_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/gfd_pkg.sv =====
// Shared types and constants of the gyro flick detector.
package gfd_pkg;

    localparam int unsigned RATE_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned FILT_W  = 24;
    localparam int unsigned LVL_W   = 15;
    localparam int unsigned ALPHA_W = 9;
    localparam int unsigned AXIS_W  = 2;
    localparam int unsigned RATIO_W = 8;
    localparam int unsigned COOL_W  = 16;
    localparam int unsigned GEST_W  = 2;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDAT_W  = 16;
    localparam int unsigned PROD_W  = RATIO_W + FILT_W;
    localparam int unsigned NUM_AXES = 3;

    // Gesture codes.
    localparam logic [GEST_W-1:0] GEST_NONE  = 2'd0;
    localparam logic [GEST_W-1:0] GEST_LEFT  = 2'd1;
    localparam logic [GEST_W-1:0] GEST_RIGHT = 2'd2;

    // Axis codes.
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CIDX_W-1:0] REG_RELEASE   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_ALPHA     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_AXIS      = 3'd3;
    localparam logic [CIDX_W-1:0] REG_RATIO     = 3'd4;
    localparam logic [CIDX_W-1:0] REG_INVERT    = 3'd5;
    localparam logic [CIDX_W-1:0] REG_COOLDOWN  = 3'd6;

    // Alpha limit and smallest nonzero dominance ratio.
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 9'd256;
    localparam logic [RATIO_W-1:0] RATIO_MIN = 8'd8;

    // Lane control: load latches the raw sample, step advances the filter.
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

    // Registered result of the merge stage.
    typedef struct packed {
        logic signed [FILT_W:0]   prim;    // primary filter value, inverted if selected
        logic [FILT_W-1:0]        mag;     // its magnitude
        logic [PROD_W-1:0]        prod;    // ratio times larger other magnitude
        logic                     dom_en;  // dominance check enabled
    } t_meas;

endpackage

// ===== sv/gfd_in_if.sv =====
// Sample channel of the gyro flick detector.
interface gfd_in_if
    import gfd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic [TIME_W-1:0]        time_now;

    modport source (output valid, rate_x, rate_y, rate_z, time_now, input ready);
    modport sink   (input valid, rate_x, rate_y, rate_z, time_now, output ready);
endinterface

// ===== sv/gfd_out_if.sv =====
// Result channel of the gyro flick detector.
interface gfd_out_if
    import gfd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [GEST_W-1:0]        gesture;
    logic signed [RATE_W-1:0] filtered_rate;

    modport source (output valid, gesture, filtered_rate, input ready);
    modport sink   (input valid, gesture, filtered_rate, output ready);
endinterface

// ===== sv/gfd_lane.sv =====
// One axis lane: sample latch and first-order low-pass filter.
module gfd_lane
    import gfd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic signed [RATE_W-1:0] i_x,
    input  logic [ALPHA_W-1:0]       i_alpha,
    output logic signed [FILT_W-1:0] o_filt,
    output logic [FILT_W-1:0]        o_mag
);

    logic signed [RATE_W-1:0]   r_x;
    logic signed [FILT_W-1:0]   r_filt;
    logic signed [FILT_W-1:0]   n_filt;
    logic signed [ALPHA_W:0]    w_a;
    logic signed [ALPHA_W:0]    w_ac;
    logic signed [25:0]         w_px;
    logic signed [33:0]         w_pf;
    logic signed [34:0]         w_acc;

    assign w_a  = signed'({1'b0, i_alpha});
    assign w_ac = signed'({1'b0, ALPHA_MAX}) - w_a;
    assign w_px = w_a * r_x;
    assign w_pf = w_ac * r_filt;
    // acc = alpha*(x*256) + (256-alpha)*old; arithmetic shift floors
    assign w_acc = 35'(signed'({w_px, 8'h00})) + 35'(w_pf);
    assign n_filt = w_acc[FILT_W+7:8];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
        end else if (i_ctl.step) begin
            r_filt <= n_filt;
        end
    end

    assign o_filt = r_filt;
    assign o_mag  = r_filt[FILT_W-1] ? FILT_W'(-r_filt) : FILT_W'(r_filt);

endmodule

// ===== sv/gfd_merge.sv =====
// Merge stage: pick the primary axis, invert, and form the dominance product.
module gfd_merge
    import gfd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [FILT_W-1:0] i_filt [NUM_AXES],
    input  logic [FILT_W-1:0]        i_mag  [NUM_AXES],
    input  logic [AXIS_W-1:0]        i_axis,
    input  logic                     i_invert,
    input  logic [RATIO_W-1:0]       i_ratio,
    output t_meas                    o_meas
);

    t_meas                    r_meas;
    t_meas                    n_meas;
    logic signed [FILT_W-1:0] w_pf;
    logic [FILT_W-1:0]        w_o1;
    logic [FILT_W-1:0]        w_o2;
    logic [FILT_W-1:0]        w_other;
    logic signed [FILT_W:0]   w_p;
    logic [RATIO_W-1:0]       w_r;

    always_comb begin
        case (i_axis)
            AXIS_X: begin
                w_pf = i_filt[0];
                w_o1 = i_mag[1];
                w_o2 = i_mag[2];
            end
            AXIS_Z: begin
                w_pf = i_filt[2];
                w_o1 = i_mag[0];
                w_o2 = i_mag[1];
            end
            default: begin
                // y, and the unused code that also selects y
                w_pf = i_filt[1];
                w_o1 = i_mag[0];
                w_o2 = i_mag[2];
            end
        endcase
        w_other = (w_o2 > w_o1) ? w_o2 : w_o1;
        w_p     = (FILT_W+1)'(w_pf);
        w_r     = (i_ratio < RATIO_MIN) ? RATIO_MIN : i_ratio;

        n_meas.prim   = i_invert ? -w_p : w_p;
        n_meas.mag    = n_meas.prim[FILT_W] ? FILT_W'(-n_meas.prim)
                                            : n_meas.prim[FILT_W-1:0];
        n_meas.prod   = w_r * w_other;
        n_meas.dom_en = (i_ratio != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meas <= n_meas;
        end
    end

    assign o_meas = r_meas;

endmodule

// ===== sv/gyro_flick_detector.sv =====
// Top level of the gyro flick detector: config, sequencing, decision, output.
// Usage:
//   i_smp carries one gyro sample per beat (rate_x/y/z, time_now in ms);
//   o_res returns exactly one beat per sample (gesture, filtered_rate).
//   Both use valid/ready; a beat moves on an edge where both are high.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the
//   user must write it only while the block is idle, which the block does
//   not enforce; indexes past the last register are ignored.
// Sequencing:
//   An accepted sample passes through the filter step in the three axis
//   lanes, the merge stage's ratio multiply and the decision compares, in
//   that order. Decide waits for a free output register and registers the
//   result there; a new sample can be taken in the cycle after that.
// Reset:
//   Synchronous, active low. Filters clear to zero, the detector is armed,
//   the cooldown end is zero and the config registers take their defaults.
// Stall:
//   The output register holds a result until it is taken; a new sample is
//   still accepted meanwhile, and the decide step waits until the output
//   register is free.
module gyro_flick_detector
    import gfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    gfd_in_if.sink            i_smp,
    gfd_out_if.source         o_res,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CDAT_W-1:0] i_cfg_data
);

`include "gyro_flick_detector_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FILT = 2'd1;
    localparam logic [1:0] S_MEAS = 2'd2;
    localparam logic [1:0] S_DEC  = 2'd3;

    // configuration
    logic [LVL_W-1:0]   r_threshold;
    logic [LVL_W-1:0]   r_release;
    logic [ALPHA_W-1:0] r_alpha;
    logic [AXIS_W-1:0]  r_axis;
    logic [RATIO_W-1:0] r_ratio;
    logic               r_invert;
    logic [COOL_W-1:0]  r_cooldown;

    // control and detector state
    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic               r_armed;
    logic [TIME_W-1:0]  r_cool_end;
    logic [TIME_W-1:0]  r_now;

    // output register
    logic                     r_out_valid;
    logic [GEST_W-1:0]        r_gesture;
    logic signed [RATE_W-1:0] r_frate;

    logic                     w_accept;
    logic                     w_dec_go;
    t_lane_ctl                w_lane_ctl;
    logic [ALPHA_W-1:0]       w_alpha;
    logic signed [RATE_W-1:0] w_x   [NUM_AXES];
    logic signed [FILT_W-1:0] w_filt [NUM_AXES];
    logic [FILT_W-1:0]        w_mag  [NUM_AXES];
    t_meas                    w_meas;

    logic                     w_rel_hit;
    logic                     w_thr_ok;
    logic                     w_cool_ok;
    logic                     w_reject;
    logic                     w_fire;
    logic [GEST_W-1:0]        w_gesture;
    logic signed [RATE_W-1:0] w_frate;
    logic                     w_res_right;

    assign w_accept = i_smp.valid && i_smp.ready;
    assign w_dec_go = (r_state == S_DEC) && (!r_out_valid || o_res.ready);
    assign i_smp.ready = (r_state == S_IDLE);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= LVL_W'(2240);
            r_release   <= LVL_W'(640);
            r_alpha     <= ALPHA_W'(115);
            r_axis      <= AXIS_Y;
            r_ratio     <= RATIO_W'(20);
            r_invert    <= 1'b0;
            r_cooldown  <= COOL_W'(450);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD: r_threshold <= i_cfg_data[LVL_W-1:0];
                REG_RELEASE:   r_release   <= i_cfg_data[LVL_W-1:0];
                REG_ALPHA:     r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                REG_AXIS:      r_axis      <= i_cfg_data[AXIS_W-1:0];
                REG_RATIO:     r_ratio     <= i_cfg_data[RATIO_W-1:0];
                REG_INVERT:    r_invert    <= i_cfg_data[0];
                REG_COOLDOWN:  r_cooldown  <= i_cfg_data[COOL_W-1:0];
                default: begin
                    // drop writes past the last register
                end
            endcase
        end
    end

    // Sequencer: idle -> filter -> merge -> decide.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_FILT;
            S_FILT: n_state = S_MEAS;
            S_MEAS: n_state = S_DEC;
            S_DEC:  if (w_dec_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now <= i_smp.time_now;
        end
    end

    // Axis lanes.
    assign w_alpha         = (r_alpha > ALPHA_MAX) ? ALPHA_MAX : r_alpha;
    assign w_lane_ctl.load = w_accept;
    assign w_lane_ctl.step = (r_state == S_FILT);
    assign w_x[0] = i_smp.rate_x;
    assign w_x[1] = i_smp.rate_y;
    assign w_x[2] = i_smp.rate_z;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        gfd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_lane_ctl),
            .i_x     (w_x[g]),
            .i_alpha (w_alpha),
            .o_filt  (w_filt[g]),
            .o_mag   (w_mag[g])
        );
    end

    gfd_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (r_state == S_MEAS),
        .i_filt   (w_filt),
        .i_mag    (w_mag),
        .i_axis   (r_axis),
        .i_invert (r_invert),
        .i_ratio  (r_ratio),
        .o_meas   (w_meas)
    );

    // Decision: hysteresis, cooldown, threshold, dominance.
    assign w_rel_hit = w_meas.mag < FILT_W'({r_release, 8'h00});
    assign w_thr_ok  = w_meas.mag >= FILT_W'({r_threshold, 8'h00});
    assign w_cool_ok = !(r_now < r_cool_end);
    assign w_reject  = w_meas.dom_en && (PROD_W'({w_meas.mag, 4'h0}) < w_meas.prod);
    assign w_fire    = !w_rel_hit && r_armed && w_cool_ok && w_thr_ok && !w_reject;
    assign w_gesture = !w_fire ? GEST_NONE :
                       (w_meas.prim > 0) ? GEST_RIGHT : GEST_LEFT;
    // floor(prim/256); only +2^23 overflows, saturate it
    assign w_frate   = (!w_meas.prim[FILT_W] && w_meas.prim[FILT_W-1]) ?
                       signed'(16'h7FFF) : w_meas.prim[FILT_W-1:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b1;
            r_cool_end <= '0;
        end else if (w_dec_go) begin
            if (w_rel_hit) begin
                r_armed <= 1'b1;
            end else if (w_fire) begin
                r_armed    <= 1'b0;
                r_cool_end <= r_now + TIME_W'(r_cooldown);
            end
        end
    end

    // Output register: hold until the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_dec_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dec_go) begin
            r_gesture <= w_gesture;
            r_frate   <= w_frate;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.gesture       = r_gesture;
    assign o_res.filtered_rate = r_frate;

    assign w_res_right = o_res.valid && (o_res.gesture == GEST_RIGHT);

    `GFD_ASSERT_NOW(a_fire_needs_arm, w_dec_go && w_fire, r_armed, "gesture fired while disarmed")
    `GFD_ASSERT_NEXT(a_fire_disarms, w_dec_go && w_fire, !r_armed, "armed flag not cleared")
    `GFD_ASSERT_NOW(a_right_nonneg, w_res_right, !r_frate[RATE_W-1], "right flick, negative rate")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the gyro flick detector: directed and random samples.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gfd_pkg::*;

    // Cycles to let pass once the last result is in, before a register write or the end.
    localparam int unsigned DRAIN_CYCLES = 8;
    // Cycles with no beat on either channel before the run is declared hung.
    localparam int unsigned STALL_LIMIT  = 2000;
    // Length of the deliberate receiver hold-off, and the results at which it starts.
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned HOLD_AT_A    = 150;
    localparam int unsigned HOLD_AT_B    = 500;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned PHASE_ITEMS  = 105;
    localparam int unsigned NUM_PHASES   = 6;
    // Index past the last register; the block must ignore writes to it.
    localparam logic [CIDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
        logic [TIME_W-1:0]        time_now;
    } t_sample;

    typedef struct packed {
        logic [GEST_W-1:0]        gesture;
        logic signed [RATE_W-1:0] filtered_rate;
    } t_flick;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CDAT_W-1:0] i_cfg_data;

    gfd_in_if  smp_if ();
    gfd_out_if res_if ();

    gyro_flick_detector DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the registers, as the block holds them.
    logic [LVL_W-1:0]   cfg_thr;
    logic [LVL_W-1:0]   cfg_rel;
    logic [ALPHA_W-1:0] cfg_alpha;
    logic [AXIS_W-1:0]  cfg_axis;
    logic [RATIO_W-1:0] cfg_ratio;
    logic               cfg_invert;
    logic [COOL_W-1:0]  cfg_cooldown;

    // Shadow detector state: three low-pass filters (8 fraction bits), arm flag, cooldown.
    logic signed [FILT_W-1:0] filt_val [NUM_AXES];
    logic                     armed;
    logic [TIME_W-1:0]        cool_end;

    t_sample           samples_to_send [$];
    t_flick            flicks_due [$];
    t_sample           held_smp;
    logic [TIME_W-1:0] stamp;
    logic              idle_on;
    int unsigned       tx_wait;
    int unsigned       rx_wait;
    int unsigned       beats_out;
    int unsigned       n_fail;
    int unsigned       stuck_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the shadow filters by one sample and decide the flick it yields.
    function automatic t_flick predict_flick(input t_sample s);
        longint      rate [NUM_AXES];
        longint      alpha;
        longint      acc;
        longint      prim;
        longint      m;
        longint      other;
        longint      ratio;
        longint      rate_q;
        int unsigned pa;
        int unsigned oa;
        int unsigned ob;
        int unsigned i;
        logic        reject;
        t_flick      res;
        rate[0] = longint'($signed(s.rate_x));
        rate[1] = longint'($signed(s.rate_y));
        rate[2] = longint'($signed(s.rate_z));
        // Alpha above full scale acts as full scale; zero freezes the filters.
        alpha = (cfg_alpha > ALPHA_MAX) ? longint'(ALPHA_MAX) : longint'(cfg_alpha);
        for (i = 0; i < NUM_AXES; i++) begin
            acc = alpha * (rate[i] * 256) + (256 - alpha) * longint'(filt_val[i]);
            filt_val[i] = FILT_W'(acc >>> 8);
        end
        // Axis code three falls back to y.
        case (cfg_axis)
            AXIS_X:  pa = 0;
            AXIS_Z:  pa = 2;
            default: pa = 1;
        endcase
        oa = (pa == 0) ? 1 : 0;
        ob = (pa == 2) ? 1 : 2;
        prim = longint'(filt_val[pa]);
        if (cfg_invert)
            prim = -prim;
        m = magnitude(prim);
        other = magnitude(longint'(filt_val[oa]));
        if (magnitude(longint'(filt_val[ob])) > other)
            other = magnitude(longint'(filt_val[ob]));

        res.gesture = GEST_NONE;
        if (m < longint'(cfg_rel) * 256) begin
            armed = 1'b1;
        end else if (armed && !(s.time_now < cool_end) && m >= longint'(cfg_thr) * 256) begin
            ratio = longint'(cfg_ratio);
            reject = 1'b0;
            if (ratio != 0) begin
                if (ratio < longint'(RATIO_MIN))
                    ratio = longint'(RATIO_MIN);
                reject = (m * 16) < (ratio * other);
            end
            if (!reject) begin
                armed = 1'b0;
                // Cooldown end wraps at 32 bits and is compared unsigned.
                cool_end = s.time_now + TIME_W'(cfg_cooldown);
                res.gesture = (prim > 0) ? GEST_RIGHT : GEST_LEFT;
            end
        end
        rate_q = prim >>> 8;
        if (rate_q > 32767)
            rate_q = 32767;
        if (rate_q < -32768)
            rate_q = -32768;
        res.filtered_rate = RATE_W'(rate_q);
        return res;
    endfunction

    // Gap before the next beat: mostly none or short, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned p;
        if (!idle_on)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int with_sign(input int unsigned mag);
        return $urandom_range(0, 1) ? -int'(mag) : int'(mag);
    endfunction

    // Step the sample clock: small steps, some long pauses, rare jumps anywhere.
    function automatic logic [TIME_W-1:0] next_stamp();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 2)
            stamp = $urandom;
        else if (p < 10)
            stamp += $urandom_range(300, 3000);
        else
            stamp += $urandom_range(1, 40);
        return stamp;
    endfunction

    task automatic queue_sample(input int x, input int y, input int z,
                                input logic [TIME_W-1:0] t);
        t_sample s;
        s.rate_x   = RATE_W'(x);
        s.rate_y   = RATE_W'(y);
        s.rate_z   = RATE_W'(z);
        s.time_now = t;
        samples_to_send.push_back(s);
    endtask

    task automatic flag_failure(input string msg);
        if (n_fail < MAX_REPORTS)
            $display("MISMATCH %s", msg);
        n_fail++;
    endtask

    // Hold until every queued sample has gone and every result is back, then settle.
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || smp_if.valid || flicks_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned value);
        logic [CDAT_W-1:0] data;
        data = CDAT_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_THRESHOLD: cfg_thr      = data[LVL_W-1:0];
            REG_RELEASE:   cfg_rel      = data[LVL_W-1:0];
            REG_ALPHA:     cfg_alpha    = data[ALPHA_W-1:0];
            REG_AXIS:      cfg_axis     = data[AXIS_W-1:0];
            REG_RATIO:     cfg_ratio    = data[RATIO_W-1:0];
            REG_INVERT:    cfg_invert   = data[0];
            REG_COOLDOWN:  cfg_cooldown = data[COOL_W-1:0];
            default: ;
        endcase
    endtask

    // Write every register; the unused upper data bits carry noise the block must drop.
    task automatic apply_config(input int unsigned thr, input int unsigned rel,
                                input int unsigned alpha, input int unsigned axis,
                                input int unsigned ratio, input int unsigned inv,
                                input int unsigned cool);
        write_reg(REG_THRESHOLD, thr   | ($urandom << LVL_W));
        write_reg(REG_RELEASE,   rel   | ($urandom << LVL_W));
        write_reg(REG_ALPHA,     alpha | ($urandom << ALPHA_W));
        write_reg(REG_AXIS,      axis  | ($urandom << AXIS_W));
        write_reg(REG_RATIO,     ratio | ($urandom << RATIO_W));
        write_reg(REG_INVERT,    inv   | ($urandom << 1));
        write_reg(REG_COOLDOWN,  cool);
        write_reg(REG_SPARE,     $urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly flick bursts on the watched axis followed by quiet stretches that re-arm;
    // bursts vary around the threshold and in cross-axis content. Some full-range noise.
    task automatic queue_random_phase(input int unsigned n_items);
        int unsigned queued;
        int unsigned burst;
        int unsigned quiet;
        int unsigned amp;
        int unsigned k;
        int unsigned pa;
        int          rate [NUM_AXES];
        int          dir;
        pa = (cfg_axis == AXIS_X) ? 0 : (cfg_axis == AXIS_Z) ? 2 : 1;
        queued = 0;
        while (queued < n_items) begin
            if ($urandom_range(0, 99) < 30) begin
                burst = $urandom_range(1, 4);
                for (k = 0; k < burst; k++)
                    queue_sample($urandom, $urandom, $urandom, next_stamp());
                queued += burst;
            end else begin
                burst = $urandom_range(1, 8);
                amp = $urandom_range(cfg_thr - cfg_thr / 4, 32767);
                dir = $urandom_range(0, 1) ? -1 : 1;
                for (k = 0; k < burst; k++) begin
                    rate[pa] = dir * int'(amp - $urandom_range(0, amp / 8));
                    rate[(pa + 1) % 3] = with_sign($urandom_range(0, amp) >> $urandom_range(0, 5));
                    rate[(pa + 2) % 3] = with_sign($urandom_range(0, amp) >> $urandom_range(0, 5));
                    queue_sample(rate[0], rate[1], rate[2], next_stamp());
                end
                quiet = $urandom_range(0, 8);
                for (k = 0; k < quiet; k++) begin
                    rate[pa] = with_sign($urandom_range(0, cfg_rel));
                    rate[(pa + 1) % 3] = with_sign($urandom_range(0, 255));
                    rate[(pa + 2) % 3] = with_sign($urandom_range(0, 255));
                    queue_sample(rate[0], rate[1], rate[2], next_stamp());
                end
                queued += burst + quiet;
            end
        end
    endtask

    // Sample driver: log the prediction for each accepted beat, then offer the next
    // pending sample after its gap. Hold payload steady while valid waits for ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (smp_if.valid && smp_if.ready)
                flicks_due.push_back(predict_flick(held_smp));
            if (!smp_if.valid || smp_if.ready) begin
                if (tx_wait != 0 || samples_to_send.size() == 0) begin
                    if (tx_wait != 0)
                        tx_wait--;
                    smp_if.valid <= 1'b0;
                end else begin
                    held_smp = samples_to_send.pop_front();
                    smp_if.valid    <= 1'b1;
                    smp_if.rate_x   <= held_smp.rate_x;
                    smp_if.rate_y   <= held_smp.rate_y;
                    smp_if.rate_z   <= held_smp.rate_z;
                    smp_if.time_now <= held_smp.time_now;
                    tx_wait = idle_gap();
                end
            end
        end
    end

    // Result monitor: check each accepted beat against the oldest prediction, then pick
    // how long to hold ready low. Twice in the run, hold off long enough to back the
    // block up into its input while the driver keeps offering.
    always @(posedge i_clk) begin
        t_flick want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (flicks_due.size() == 0) begin
                    flag_failure($sformatf("result %0d arrived with none expected (gesture %0d)",
                                           beats_out, res_if.gesture));
                end else begin
                    want = flicks_due.pop_front();
                    if (res_if.gesture !== want.gesture)
                        flag_failure($sformatf("result %0d gesture: expected %0d, got %0d",
                                               beats_out, want.gesture, res_if.gesture));
                    if (res_if.filtered_rate !== want.filtered_rate)
                        flag_failure($sformatf("result %0d filtered_rate: expected %0d, got %0d",
                                               beats_out, $signed(want.filtered_rate),
                                               $signed(res_if.filtered_rate)));
                end
                beats_out++;
                rx_wait = (beats_out == HOLD_AT_A || beats_out == HOLD_AT_B) ? LONG_HOLD
                                                                             : idle_gap();
            end
            if (rx_wait != 0) begin
                rx_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: abort if neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int unsigned phase;
        int unsigned thr;
        int unsigned p;
        // Drive every input to a known value before the first edge.
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_THRESHOLD;
        i_cfg_data      = '0;
        smp_if.valid    = 1'b0;
        smp_if.rate_x   = '0;
        smp_if.rate_y   = '0;
        smp_if.rate_z   = '0;
        smp_if.time_now = '0;
        res_if.ready    = 1'b0;
        stuck_cycles    = 0;
        n_fail          = 0;
        beats_out       = 0;
        idle_on         = 1'b1;
        stamp           = '0;
        // Shadow state after reset.
        cfg_thr      = 2240;
        cfg_rel      = 640;
        cfg_alpha    = 115;
        cfg_axis     = AXIS_Y;
        cfg_ratio    = 20;
        cfg_invert   = 1'b0;
        cfg_cooldown = 450;
        filt_val[0]  = '0;
        filt_val[1]  = '0;
        filt_val[2]  = '0;
        armed        = 1'b1;
        cool_end     = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: zero, all-max and all-min samples.
        queue_sample(0, 0, 0, 0);
        queue_sample(32767, 32767, 32767, 1);
        queue_sample(-32768, -32768, -32768, 2);
        queue_sample(0, 0, 0, 3);
        wait_drained();

        // Unfiltered z, inverted, no dominance test, no cooldown window.
        // Inverting the most negative rate must saturate the reported rate.
        apply_config(100, 50, 256, AXIS_Z, 0, 1, 0);
        queue_sample(0, 0, -32768, 10);
        queue_sample(0, 0, 0, 11);
        queue_sample(32767, -32768, 32767, 12);
        queue_sample(0, 0, 0, 13);
        queue_sample(0, 0, 5000, 13);
        wait_drained();

        // Alpha past full scale, axis code three, small ratio, top levels and cooldown.
        // The cooldown end wraps past zero: a flick just before the wrap still fires,
        // one just after it is blocked.
        apply_config(32767, 32767, 511, 3, 5, 0, 65535);
        queue_sample(0, 0, 0, 32'hFFFF_FE00);
        queue_sample(0, -32768, 0, 32'hFFFF_FF00);
        queue_sample(0, 0, 0, 32'hFFFF_FF10);
        queue_sample(0, 32767, 0, 32'hFFFF_FF20);
        queue_sample(0, 0, 0, 32'h0000_0010);
        queue_sample(0, 32767, 0, 32'h0000_0020);
        wait_drained();

        // Strict dominance on x; the previous test's cooldown end still blocks all three flicks.
        apply_config(10, 5, 256, AXIS_X, 255, 0, 1);
        queue_sample(0, 0, 0, 100);
        queue_sample(4000, 0, -2000, 200);
        queue_sample(32767, -32768, 0, 300);
        queue_sample(-32768, 100, -100, 400);
        wait_drained();

        // Alpha zero: filters must hold whatever the input does.
        apply_config(0, 0, 0, AXIS_Z, 1, 1, 1);
        queue_sample(32767, 32767, 32767, 500);
        queue_sample(-32768, 0, -32768, 600);
        wait_drained();

        stamp = 1000;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: begin
                    // Lowest settings, no random gaps between beats on either side.
                    idle_on = 1'b0;
                    apply_config(0, 0, 1, AXIS_X, 0, 0, 1);
                end
                3: begin
                    idle_on = 1'b1;
                    apply_config(32767, 32767, 256, AXIS_Z, 255, 1, 65535);
                end
                default: begin
                    idle_on = (phase != 4);
                    thr = $urandom_range(200, 4000);
                    p = $urandom_range(0, 99);
                    apply_config(thr, $urandom_range(0, thr),
                                 (p < 8) ? $urandom_range(257, 511) : $urandom_range(32, 256),
                                 $urandom_range(0, 3),
                                 (p < 20) ? 0 : (p < 35) ? $urandom_range(1, 7)
                                                         : $urandom_range(8, 255),
                                 $urandom_range(0, 1),
                                 (p < 10) ? 0 : $urandom_range(1, 600));
                end
            endcase
            queue_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (n_fail == 0 && flicks_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/gfd_pkg.sv
sv/gfd_in_if.sv
sv/gfd_out_if.sv
sv/gfd_lane.sv
sv/gfd_merge.sv
sv/gyro_flick_detector.sv
sim/testbench.sv
